FILE: rtl/core/ahs_pkg.sv
// ----------------------------------------------------------------------------
// ahs_pkg
// types and constants shared by the axis homing sequencer
// ----------------------------------------------------------------------------
package ahs_pkg;

   localparam int unsigned SPEED_W = 16;
   localparam int unsigned ACCEL_W = 8;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned COUNT_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_APPROACH_SPEED = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF_SPEED = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CREEP_SPEED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_APPROACH_ACCEL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF_ACCEL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_TICKS = 3'd5;

   localparam logic [SPEED_W-1:0] RST_APPROACH_SPEED = 16'd10;
   localparam logic [SPEED_W-1:0] RST_BACKOFF_SPEED = 16'd1;
   localparam logic [SPEED_W-1:0] RST_CREEP_SPEED = 16'd3;
   localparam logic [ACCEL_W-1:0] RST_APPROACH_ACCEL = 8'd150;
   localparam logic [ACCEL_W-1:0] RST_BACKOFF_ACCEL = 8'd50;
   localparam logic [SPEED_W-1:0] RST_SETTLE_TICKS = 16'd500;

   typedef enum logic [2:0] {
      CMD_NONE   = 3'd0,
      CMD_AWAY   = 3'd1,
      CMD_TOWARD = 3'd2,
      CMD_STOP   = 3'd3,
      CMD_CREEP  = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [SPEED_W-1:0] approach_speed;
      logic [SPEED_W-1:0] backoff_speed;
      logic [SPEED_W-1:0] creep_speed;
      logic [ACCEL_W-1:0] approach_accel;
      logic [ACCEL_W-1:0] backoff_accel;
      logic [SPEED_W-1:0] settle_ticks;
   } cfg_type;

   typedef struct packed {
      cmd_type            command;
      logic [SPEED_W-1:0] command_speed;
      logic [ACCEL_W-1:0] command_accel;
      logic               homing_active;
   } rsp_type;

endpackage

FILE: rtl/core/axis_homing_sequencer_top.sv
// ----------------------------------------------------------------------------
// axis_homing_sequencer_top
// homing sequencer for one stepper axis, one command word per request word
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall| start_req, at_home, axis_busy, tick
//  rsp     | out       | rsp_valid/rsp_stall| command, command_speed, command_accel,
//          |           |                    | homing_active
//  csr     | in        | csr_write_en       | csr_index, csr_wdata
//
//  one request word per cycle while req_stall is low; its command word appears in the cycle after accept
//  the command word is held in the single result register behind the step logic
//  reset clears the step, the settle count and the registers to their defaults
//  req_stall is raised only while a held command word is stalled
// ----------------------------------------------------------------------------
module axis_homing_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_start_req,
   input  logic        req_at_home,
   input  logic        req_axis_busy,
   input  logic        req_tick,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_command,
   output logic [15:0] rsp_command_speed,
   output logic [7:0]  rsp_command_accel,
   output logic        rsp_homing_active,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   ahs_pkg::cfg_type cfg_ff;
   ahs_pkg::rsp_type rsp;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.approach_speed <= ahs_pkg::RST_APPROACH_SPEED;
         cfg_ff.backoff_speed  <= ahs_pkg::RST_BACKOFF_SPEED;
         cfg_ff.creep_speed    <= ahs_pkg::RST_CREEP_SPEED;
         cfg_ff.approach_accel <= ahs_pkg::RST_APPROACH_ACCEL;
         cfg_ff.backoff_accel  <= ahs_pkg::RST_BACKOFF_ACCEL;
         cfg_ff.settle_ticks   <= ahs_pkg::RST_SETTLE_TICKS;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ahs_pkg::CSR_APPROACH_SPEED: cfg_ff.approach_speed <= csr_wdata;
            ahs_pkg::CSR_BACKOFF_SPEED:  cfg_ff.backoff_speed  <= csr_wdata;
            ahs_pkg::CSR_CREEP_SPEED:    cfg_ff.creep_speed    <= csr_wdata;
            ahs_pkg::CSR_APPROACH_ACCEL: cfg_ff.approach_accel <= csr_wdata[7:0];
            ahs_pkg::CSR_BACKOFF_ACCEL:  cfg_ff.backoff_accel  <= csr_wdata[7:0];
            ahs_pkg::CSR_SETTLE_TICKS:   cfg_ff.settle_ticks   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   ahs_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .start_req (req_start_req),
      .at_home   (req_at_home),
      .axis_busy (req_axis_busy),
      .tick      (req_tick),
      .cfg       (cfg_ff),
      .rsp       (rsp)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_command       = rsp.command;
   assign rsp_command_speed = rsp.command_speed;
   assign rsp_command_accel = rsp.command_accel;
   assign rsp_homing_active = rsp.homing_active;

endmodule

FILE: rtl/core/ahs_seq.sv
// ----------------------------------------------------------------------------
// ahs_seq
// homing step sequencer: evaluates one word per accept and registers the
// resulting command
// ----------------------------------------------------------------------------
module ahs_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              start_req,
   input  logic              at_home,
   input  logic              axis_busy,
   input  logic              tick,
   input  ahs_pkg::cfg_type  cfg,
   output ahs_pkg::rsp_type  rsp
);

   typedef enum logic [3:0] {
      ST_IDLE       = 4'd0,
      ST_CHECK      = 4'd1,
      ST_PRE_APPR   = 4'd2,
      ST_APPROACH   = 4'd3,
      ST_WAIT_IDLE  = 4'd4,
      ST_CREEP      = 4'd5,
      ST_CREEP_WAIT = 4'd6,
      ST_PRE_BACK   = 4'd7,
      ST_BACKOFF    = 4'd8,
      ST_SETTLE     = 4'd9
   } step_type;

   step_type                        step_ff, step_in, step_cur;
   logic [ahs_pkg::COUNT_W-1:0]     count_ff, count_in, count_cur, count_inc;
   logic [ahs_pkg::COUNT_W-1:0]     limit;
   ahs_pkg::rsp_type                rsp_ff, rsp_in;

   always_comb begin
      step_cur  = start_req ? ST_CHECK : step_ff;
      count_cur = start_req ? '0 : count_ff;
      limit     = {1'b0, cfg.settle_ticks};
      count_inc = (tick && (count_cur <= limit)) ? count_cur + 1'b1 : count_cur;

      step_in  = step_cur;
      count_in = count_cur;
      rsp_in.command       = ahs_pkg::CMD_NONE;
      rsp_in.command_speed = '0;
      rsp_in.command_accel = '0;

      unique case (step_cur)
         ST_IDLE: begin
         end
         ST_CHECK: begin
            if (at_home) begin
               step_in = ST_BACKOFF;
               rsp_in.command       = ahs_pkg::CMD_AWAY;
               rsp_in.command_speed = cfg.backoff_speed;
               rsp_in.command_accel = cfg.backoff_accel;
            end else begin
               step_in = ST_PRE_APPR;
            end
         end
         ST_PRE_APPR: begin
            if (!axis_busy) begin
               step_in = ST_APPROACH;
               rsp_in.command       = ahs_pkg::CMD_TOWARD;
               rsp_in.command_speed = cfg.approach_speed;
               rsp_in.command_accel = cfg.approach_accel;
            end
         end
         ST_APPROACH: begin
            if (at_home) begin
               step_in = ST_PRE_BACK;
               rsp_in.command = ahs_pkg::CMD_STOP;
            end
         end
         ST_WAIT_IDLE: begin
            if (!axis_busy) step_in = ST_CREEP;
         end
         ST_CREEP: begin
            if (!axis_busy) begin
               step_in = ST_CREEP_WAIT;
               rsp_in.command       = ahs_pkg::CMD_CREEP;
               rsp_in.command_speed = cfg.creep_speed;
            end
         end
         ST_CREEP_WAIT: begin
            if (!axis_busy) begin
               step_in  = ST_SETTLE;
               count_in = '0;
            end
         end
         ST_PRE_BACK: begin
            if (!axis_busy) begin
               step_in = ST_BACKOFF;
               rsp_in.command       = ahs_pkg::CMD_AWAY;
               rsp_in.command_speed = cfg.backoff_speed;
               rsp_in.command_accel = cfg.backoff_accel;
            end
         end
         ST_BACKOFF: begin
            if (!at_home) begin
               step_in = ST_WAIT_IDLE;
               rsp_in.command = ahs_pkg::CMD_STOP;
            end
         end
         ST_SETTLE: begin
            count_in = count_inc;
            if (count_inc > limit) begin
               step_in = ST_IDLE;
               rsp_in.command = ahs_pkg::CMD_CLEAR;
            end
         end
         default: begin
            step_in = ST_IDLE;
         end
      endcase

      rsp_in.homing_active = (step_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= ST_IDLE;
         count_ff <= '0;
      end else if (accept) begin
         step_ff  <= step_in;
         count_ff <= count_in;
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

FILE: verif/axis_homing_sequencer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_homing_sequencer_top_tb
// self-checking bench for the axis homing sequencer: directed homing runs on
// and off the switch, restarts, settle times at the register extremes, a long
// output hold, then random polls under random idling on both channels, every
// command word compared with an in-bench prediction of the step logic
// ----------------------------------------------------------------------------
module axis_homing_sequencer_top_tb;

   localparam int LIMIT = 50000;
   localparam int HOLD_CYCLES = 48;
   localparam int SETTLE_PROBE = 24;
   localparam int LONG_SETTLE_PROBE = 20;
   localparam int RANDOM_PER_PHASE = 85;
   localparam logic [ahs_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [ahs_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_WAIT_APPROACH, ST_APPROACHING, ST_WAIT_IDLE,
      ST_CREEP_START, ST_CREEP_WAIT, ST_WAIT_BACKOFF, ST_BACKING_OFF, ST_SETTLING
   } step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_start_req = 1'b0;
   logic        req_at_home = 1'b0;
   logic        req_axis_busy = 1'b0;
   logic        req_tick = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_command;
   logic [15:0] rsp_command_speed;
   logic [7:0]  rsp_command_accel;
   logic        rsp_homing_active;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   logic burst_stall = 1'b0;
   logic hold_stall = 1'b0;
   event hold_go;
   bit   gaps_on = 1'b1;

   step_type                             home_step;
   logic [ahs_pkg::COUNT_W-1:0]          settle_count;
   ahs_pkg::cfg_type                     cfg;
   ahs_pkg::rsp_type                     expected_cmds[$];
   ahs_pkg::rsp_type                     due_word;

   int cycle_count = 0;
   int mismatches = 0;
   int words_sent = 0;
   int words_checked = 0;
   int random_words = 0;

   assign rsp_stall = burst_stall | hold_stall;

   axis_homing_sequencer_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_start_req(req_start_req), .req_at_home(req_at_home),
      .req_axis_busy(req_axis_busy), .req_tick(req_tick),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_command(rsp_command), .rsp_command_speed(rsp_command_speed),
      .rsp_command_accel(rsp_command_accel), .rsp_homing_active(rsp_homing_active),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  expected_cmds.size());
         $display("FAIL");
         $finish;
      end
   end

   // one poll of the step logic, advancing the predicted state
   function automatic ahs_pkg::rsp_type next_command(input logic start, home, busy, tick);
      ahs_pkg::rsp_type r;
      r.command = ahs_pkg::CMD_NONE;
      r.command_speed = '0;
      r.command_accel = '0;
      if (start) begin
         home_step = ST_CHECK;
         settle_count = '0;
      end
      case (home_step)
         ST_CHECK: begin
            if (home) begin
               home_step = ST_BACKING_OFF;
               r.command = ahs_pkg::CMD_AWAY;
               r.command_speed = cfg.backoff_speed;
               r.command_accel = cfg.backoff_accel;
            end else begin
               home_step = ST_WAIT_APPROACH;
            end
         end
         ST_WAIT_APPROACH: begin
            if (!busy) begin
               home_step = ST_APPROACHING;
               r.command = ahs_pkg::CMD_TOWARD;
               r.command_speed = cfg.approach_speed;
               r.command_accel = cfg.approach_accel;
            end
         end
         ST_APPROACHING: begin
            if (home) begin
               home_step = ST_WAIT_BACKOFF;
               r.command = ahs_pkg::CMD_STOP;
            end
         end
         ST_WAIT_IDLE: begin
            if (!busy) home_step = ST_CREEP_START;
         end
         ST_CREEP_START: begin
            if (!busy) begin
               home_step = ST_CREEP_WAIT;
               r.command = ahs_pkg::CMD_CREEP;
               r.command_speed = cfg.creep_speed;
            end
         end
         ST_CREEP_WAIT: begin
            if (!busy) begin
               home_step = ST_SETTLING;
               settle_count = '0;
            end
         end
         ST_WAIT_BACKOFF: begin
            if (!busy) begin
               home_step = ST_BACKING_OFF;
               r.command = ahs_pkg::CMD_AWAY;
               r.command_speed = cfg.backoff_speed;
               r.command_accel = cfg.backoff_accel;
            end
         end
         ST_BACKING_OFF: begin
            if (!home) begin
               home_step = ST_WAIT_IDLE;
               r.command = ahs_pkg::CMD_STOP;
            end
         end
         ST_SETTLING: begin
            if (tick && settle_count <= cfg.settle_ticks) settle_count = settle_count + 1'b1;
            if (settle_count > cfg.settle_ticks) begin
               home_step = ST_IDLE;
               r.command = ahs_pkg::CMD_CLEAR;
            end
         end
         default: home_step = ST_IDLE;
      endcase
      r.homing_active = (home_step != ST_IDLE);
      return r;
   endfunction

   // results checked first: a word accepted at this edge answers at a later one
   always @(posedge clock) begin
      if (reset) begin
         home_step = ST_IDLE;
         settle_count = '0;
         cfg = '{ahs_pkg::RST_APPROACH_SPEED, ahs_pkg::RST_BACKOFF_SPEED,
                 ahs_pkg::RST_CREEP_SPEED, ahs_pkg::RST_APPROACH_ACCEL,
                 ahs_pkg::RST_BACKOFF_ACCEL, ahs_pkg::RST_SETTLE_TICKS};
         expected_cmds.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cmds.size() == 0) begin
               if (mismatches < 10)
                  $display("cycle %0d: command word %0d with none expected", cycle_count,
                           rsp_command);
               mismatches++;
            end else begin
               due_word = expected_cmds.pop_front();
               words_checked++;
               if (rsp_command !== due_word.command ||
                   rsp_command_speed !== due_word.command_speed ||
                   rsp_command_accel !== due_word.command_accel ||
                   rsp_homing_active !== due_word.homing_active) begin
                  if (mismatches < 10)
                     $display("cycle %0d: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                              cycle_count, due_word.command, due_word.command_speed,
                              due_word.command_accel, due_word.homing_active, rsp_command,
                              rsp_command_speed, rsp_command_accel, rsp_homing_active);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_cmds.push_back(next_command(req_start_req, req_at_home, req_axis_busy,
                                                 req_tick));
         if (csr_write_en) begin
            case (csr_index)
               ahs_pkg::CSR_APPROACH_SPEED: cfg.approach_speed = csr_wdata;
               ahs_pkg::CSR_BACKOFF_SPEED:  cfg.backoff_speed = csr_wdata;
               ahs_pkg::CSR_CREEP_SPEED:    cfg.creep_speed = csr_wdata;
               ahs_pkg::CSR_APPROACH_ACCEL:
                  cfg.approach_accel = csr_wdata[ahs_pkg::ACCEL_W-1:0];
               ahs_pkg::CSR_BACKOFF_ACCEL:
                  cfg.backoff_accel = csr_wdata[ahs_pkg::ACCEL_W-1:0];
               ahs_pkg::CSR_SETTLE_TICKS:   cfg.settle_ticks = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // random output stalls, with calm stretches in between
   always begin
      @(negedge clock);
      if (gaps_on) begin
         case ($urandom_range(0, 7))
            0: begin
               burst_stall = 1'b1;
               repeat ($urandom_range(1, 13)) @(negedge clock);
               burst_stall = 1'b0;
            end
            1: repeat ($urandom_range(20, 60)) @(negedge clock);
            default: ;
         endcase
      end
   end

   // long output hold, counted here while the sender keeps offering
   always begin
      @(hold_go);
      hold_stall = 1'b1;
      for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clock);
      hold_stall = 1'b0;
   end

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic send_word(input logic start, home, busy, tick);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_start_req = start;
      req_at_home = home;
      req_axis_busy = busy;
      req_tick = tick;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
      words_sent++;
   endtask

   task automatic send_random_word();
      logic start;
      start = (home_step == ST_IDLE) ? ($urandom_range(0, 3) == 0)
                                     : ($urandom_range(0, 59) == 0);
      if (start || home_step != ST_IDLE) random_words++;
      send_word(start, coin(), coin(), coin());
   endtask

   task automatic write_reg(input logic [ahs_pkg::CSR_IDX_W-1:0] index,
                            input logic [15:0] value);
      csr_index = index;
      csr_wdata = value;
      csr_write_en = 1'b1;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic drain_commands();
      while (expected_cmds.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // shortest legal run from a start up to the settle step
   task automatic drive_to_settle(input logic on_switch);
      if (on_switch) begin
         send_word(1'b1, 1'b1, coin(), coin());
      end else begin
         send_word(1'b1, 1'b0, coin(), coin());
         send_word(1'b0, coin(), 1'b0, coin());
         send_word(1'b0, 1'b1, coin(), coin());
         send_word(1'b0, coin(), 1'b0, coin());
      end
      send_word(1'b0, 1'b0, coin(), coin());
      send_word(1'b0, coin(), 1'b0, coin());
      send_word(1'b0, coin(), 1'b0, coin());
      send_word(1'b0, coin(), 1'b0, 1'b1);
   endtask

   task automatic tick_until_clear(input int ticks);
      for (int i = 0; i < ticks; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_word(1'b0, coin(), coin(), 1'b0);
         send_word(1'b0, coin(), coin(), 1'b1);
      end
   endtask

   task automatic test_directed();
      send_word(1'b0, 1'b0, 1'b0, 1'b0);
      send_word(1'b0, 1'b1, 1'b1, 1'b1);
      // start on the switch: back off at once
      send_word(1'b1, 1'b1, 1'b0, 1'b0);
      send_word(1'b0, 1'b1, 1'b1, 1'b1);
      send_word(1'b0, 1'b0, 1'b1, 1'b0);
      send_word(1'b0, 1'b0, 1'b1, 1'b0);
      send_word(1'b0, 1'b0, 1'b0, 1'b0);
      send_word(1'b0, 1'b1, 1'b1, 1'b0);
      send_word(1'b0, 1'b1, 1'b0, 1'b0);
      send_word(1'b0, 1'b0, 1'b1, 1'b1);
      // restart during the creep
      send_word(1'b1, 1'b0, 1'b1, 1'b0);
      send_word(1'b0, 1'b0, 1'b1, 1'b0);
      send_word(1'b0, 1'b0, 1'b0, 1'b0);
      send_word(1'b0, 1'b0, 1'b0, 1'b1);
      send_word(1'b0, 1'b1, 1'b1, 1'b0);
      send_word(1'b0, 1'b1, 1'b1, 1'b0);
      send_word(1'b0, 1'b1, 1'b0, 1'b0);
      send_word(1'b0, 1'b0, 1'b0, 1'b0);
      send_word(1'b0, 1'b0, 1'b0, 1'b0);
      send_word(1'b0, 1'b0, 1'b0, 1'b0);
      // tick on entry to settle is not counted
      send_word(1'b0, 1'b0, 1'b0, 1'b1);
   endtask

   task automatic test_default_settle();
      tick_until_clear(SETTLE_PROBE);
   endtask

   task automatic test_register_extremes();
      drain_commands();
      for (int i = int'(ahs_pkg::CSR_APPROACH_SPEED); i <= int'(ahs_pkg::CSR_SETTLE_TICKS);
           i++)
         write_reg(i[ahs_pkg::CSR_IDX_W-1:0], 16'hFFFF);
      write_reg(CSR_SPARE_LO, 16'($urandom));
      write_reg(CSR_SPARE_HI, 16'($urandom));
      gaps_on = 1'b0;
      drive_to_settle(1'b1);
      drive_to_settle(1'b0);
      tick_until_clear(LONG_SETTLE_PROBE);
      gaps_on = 1'b1;
      drain_commands();
      for (int i = int'(ahs_pkg::CSR_APPROACH_SPEED); i <= int'(ahs_pkg::CSR_SETTLE_TICKS);
           i++)
         write_reg(i[ahs_pkg::CSR_IDX_W-1:0], 16'h0000);
      drive_to_settle(1'b0);
      send_word(1'b0, 1'b1, 1'b1, 1'b0);
      tick_until_clear(1);
      drive_to_settle(1'b1);
      tick_until_clear(1);
   endtask

   task automatic test_backpressure();
      drain_commands();
      gaps_on = 1'b0;
      send_word(1'b1, coin(), coin(), coin());
      -> hold_go;
      repeat (30) send_random_word();
      gaps_on = 1'b1;
   endtask

   task automatic test_random();
      int target;
      for (int phase = 0; phase < 4; phase++) begin
         drain_commands();
         gaps_on = (phase < 3);
         write_reg(ahs_pkg::CSR_APPROACH_SPEED, pick_value());
         write_reg(ahs_pkg::CSR_BACKOFF_SPEED, pick_value());
         write_reg(ahs_pkg::CSR_CREEP_SPEED, pick_value());
         write_reg(ahs_pkg::CSR_APPROACH_ACCEL, pick_value());
         write_reg(ahs_pkg::CSR_BACKOFF_ACCEL, pick_value());
         write_reg(ahs_pkg::CSR_SETTLE_TICKS, 16'($urandom_range(0, 6)));
         if ($urandom_range(0, 1) == 0)
            write_reg($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, 16'($urandom));
         target = random_words + RANDOM_PER_PHASE;
         while (random_words < target) send_random_word();
      end
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_default_settle();
      test_register_extremes();
      test_backpressure();
      test_random();
      gaps_on = 1'b0;
      drain_commands();
      repeat (4) @(negedge clock);
      $display("%0d request words sent, %0d command words checked, %0d random polls",
               words_sent, words_checked, random_words);
      $display("both homing paths, restarts, settle at zero and at the top limit, output hold");
      if (mismatches == 0 && expected_cmds.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/ahs_pkg.sv
rtl/core/ahs_seq.sv
rtl/core/axis_homing_sequencer_top.sv
verif/axis_homing_sequencer_top_tb.sv
